@@ hdl/ppa_pkg.sv @@
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and constants for the parking proximity alarm
// Item kinds, register indexes, state and result records, beep periods.
// ----------------------------------------------------------------------------
package ppa_pkg;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_ECHO = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_NEAREST_DISTANCE   = 2'd0,
      REG_DISTANCE_STEP      = 2'd1,
      REG_BEEP_HOLD_LIMIT    = 2'd2,
      REG_DISPLAY_HOLD_LIMIT = 2'd3
   } reg_index_type;

   localparam int unsigned BAR_SIZE = 9;

   // Divide by 58 as multiply by ceil(2^21 / 58) and shift; exact for 16-bit widths.
   localparam logic [15:0] CM_RECIP_MULT  = 16'd36158;
   localparam int unsigned CM_RECIP_SHIFT = 21;

   localparam logic [15:0] SLOW_BLINK        = 16'd50;
   localparam logic [15:0] DISPLAY_COUNT_CAP = 16'd60000;

   localparam logic [7:0]  NEAREST_DISTANCE_RESET   = 8'd20;
   localparam logic [4:0]  DISTANCE_STEP_RESET      = 5'd6;
   localparam logic [15:0] BEEP_HOLD_LIMIT_RESET    = 16'd700;
   localparam logic [15:0] DISPLAY_HOLD_LIMIT_RESET = 16'd1500;

   localparam logic [3:0] LEVEL_BEEP_LOW  = 4'd4;
   localparam logic [3:0] LEVEL_HOLD_CLR  = 4'd7;
   localparam logic [3:0] LEVEL_BEEP_HIGH = 4'd8;
   localparam logic [3:0] LEVEL_STEADY    = 4'd9;

   typedef struct packed {
      logic [7:0]  nearest_distance;
      logic [4:0]  distance_step;
      logic [15:0] beep_hold_limit;
      logic [15:0] display_hold_limit;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  level;
      logic [15:0] blink_count;
      logic [15:0] beep_count;
      logic [15:0] beep_hold_count;
      logic [15:0] display_hold_count;
      logic        beeper_bit;
      logic        status_bit;
      logic [8:0]  bar_bits;
   } state_type;

   typedef struct packed {
      logic [8:0]  bar_bits;
      logic [3:0]  level;
      logic [10:0] distance_cm;
   } echo_result_type;

   typedef struct packed {
      logic        beeper;
      logic        status_led;
      logic [8:0]  bar_leds;
      logic [3:0]  proximity_level;
      logic [10:0] distance_cm;
      logic        report_valid;
   } rsp_type;

   // Beeper toggle period in ticks for levels 4 to 8.
   function automatic logic [5:0] beep_period(input logic [3:0] level);
      logic [5:0] period;
      case (level)
         4'd4:    period = 6'd40;
         4'd5:    period = 6'd20;
         4'd6:    period = 6'd10;
         4'd7:    period = 6'd5;
         4'd8:    period = 6'd2;
         default: period = 6'd40;
      endcase
      return period;
   endfunction

endpackage

@@ hdl/ppa_if.sv @@
// ----------------------------------------------------------------------------
// ppa_if: channel interfaces of the parking proximity alarm
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ppa_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] echo_us;
   logic        beep_mute;
   logic        display_off;

   modport source (output valid, operation, echo_us, beep_mute, display_off, input ready);
   modport sink   (input valid, operation, echo_us, beep_mute, display_off, output ready);
endinterface

interface ppa_rsp_if;
   logic        valid;
   logic        ready;
   logic        beeper;
   logic        status_led;
   logic [8:0]  bar_leds;
   logic [3:0]  proximity_level;
   logic [10:0] distance_cm;
   logic        report_valid;

   modport source (output valid, beeper, status_led, bar_leds, proximity_level,
                   distance_cm, report_valid, input ready);
   modport sink   (input valid, beeper, status_led, bar_leds, proximity_level,
                   distance_cm, report_valid, output ready);
endinterface

interface ppa_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/parking_proximity_alarm.sv @@
// ----------------------------------------------------------------------------
// parking_proximity_alarm: ultrasonic parking aid with LED bar and beeper
// Path: a request transaction passes through the input register, then the result
//   register; throughput is one transaction per cycle while the response side is
//   ready, with the alarm state updated once per transaction.
// Reset (synchronous, active high) clears all alarm state and loads the
//   register defaults; register writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
module parking_proximity_alarm (
   input  logic           clock,
   input  logic           reset,
   ppa_req_if.sink        req_if,
   ppa_rsp_if.source      rsp_if,
   ppa_csr_if.sink        csr_if
);

   // Configuration registers
   ppa_pkg::cfg_type cfg_ff;

   // Input stage: holds one request transaction
   logic        s1_valid_ff;
   logic        s1_op_ff;
   logic [15:0] s1_echo_ff;
   logic        s1_mute_ff;
   logic        s1_dark_ff;

   // Alarm state and its next value
   ppa_pkg::state_type state_ff;
   ppa_pkg::state_type state_in;

   // Result register
   logic             out_valid_ff;
   ppa_pkg::rsp_type out_ff;
   ppa_pkg::rsp_type out_in;

   ppa_pkg::echo_result_type echo_res;
   ppa_pkg::state_type       tick_state;

   logic s1_move;
   logic req_take;

   // Advance the input stage whenever the result register is free or drains now.
   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !s1_valid_ff || s1_move;
   assign csr_if.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nearest_distance   <= ppa_pkg::NEAREST_DISTANCE_RESET;
         cfg_ff.distance_step      <= ppa_pkg::DISTANCE_STEP_RESET;
         cfg_ff.beep_hold_limit    <= ppa_pkg::BEEP_HOLD_LIMIT_RESET;
         cfg_ff.display_hold_limit <= ppa_pkg::DISPLAY_HOLD_LIMIT_RESET;
      end else if (csr_if.valid) begin
         case (ppa_pkg::reg_index_type'(csr_if.index))
            ppa_pkg::REG_NEAREST_DISTANCE:   cfg_ff.nearest_distance   <= csr_if.data[7:0];
            ppa_pkg::REG_DISTANCE_STEP:      cfg_ff.distance_step      <= csr_if.data[4:0];
            ppa_pkg::REG_BEEP_HOLD_LIMIT:    cfg_ff.beep_hold_limit    <= csr_if.data;
            ppa_pkg::REG_DISPLAY_HOLD_LIMIT: cfg_ff.display_hold_limit <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Capture a request transaction into the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_if.operation;
         s1_echo_ff <= req_if.echo_us;
         s1_mute_ff <= req_if.beep_mute;
         s1_dark_ff <= req_if.display_off;
      end
   end

   ppa_echo u_echo (
      .echo_us (s1_echo_ff),
      .cfg     (cfg_ff),
      .result  (echo_res)
   );

   ppa_tick u_tick (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .mute (s1_mute_ff),
      .nxt  (tick_state)
   );

   // Pick the state update by transaction kind; echoes leave beeper and LED alone.
   always_comb begin
      if (ppa_pkg::op_type'(s1_op_ff) == ppa_pkg::OP_ECHO) begin
         state_in       = state_ff;
         state_in.level = echo_res.level;
         if (!s1_dark_ff && (state_ff.display_hold_count < cfg_ff.display_hold_limit)) begin
            state_in.bar_bits = echo_res.bar_bits;
         end else begin
            state_in.bar_bits = '0;
         end
      end else begin
         state_in = tick_state;
      end
   end

   always_comb begin
      out_in.beeper          = state_in.beeper_bit;
      out_in.status_led      = state_in.status_bit;
      out_in.bar_leds        = state_in.bar_bits;
      out_in.proximity_level = state_in.level;
      if (ppa_pkg::op_type'(s1_op_ff) == ppa_pkg::OP_ECHO) begin
         out_in.distance_cm  = echo_res.distance_cm;
         out_in.report_valid = 1'b1;
      end else begin
         out_in.distance_cm  = '0;
         out_in.report_valid = 1'b0;
      end
   end

   // Commit state and result together as the transaction leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_move) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.beeper          = out_ff.beeper;
   assign rsp_if.status_led      = out_ff.status_led;
   assign rsp_if.bar_leds        = out_ff.bar_leds;
   assign rsp_if.proximity_level = out_ff.proximity_level;
   assign rsp_if.distance_cm     = out_ff.distance_cm;
   assign rsp_if.report_valid    = out_ff.report_valid;

endmodule

@@ hdl/ppa_echo.sv @@
// ----------------------------------------------------------------------------
// ppa_echo: echo width to distance, bar pattern and proximity level
// Reciprocal divide by 58, nine saturated thresholds, lit-bit count.
// ----------------------------------------------------------------------------
module ppa_echo (
   input  logic [15:0]               echo_us,
   input  ppa_pkg::cfg_type          cfg,
   output ppa_pkg::echo_result_type  result
);

   logic [31:0] product;
   logic [10:0] dist_cm;
   logic [7:0]  dist_sat;
   logic [8:0]  bits;
   logic [3:0]  count;

   assign product  = 32'(echo_us) * 32'(ppa_pkg::CM_RECIP_MULT);
   assign dist_cm  = product[31:ppa_pkg::CM_RECIP_SHIFT];
   assign dist_sat = (dist_cm > 11'd255) ? 8'hFF : dist_cm[7:0];

   for (genvar i = 0; i < ppa_pkg::BAR_SIZE; i++) begin : g_thr
      logic [8:0] thr;
      logic [7:0] thr_sat;
      assign thr     = 9'(cfg.nearest_distance) + 9'(cfg.distance_step) * 9'(i);
      assign thr_sat = thr[8] ? 8'hFF : thr[7:0];
      assign bits[i] = (dist_sat < thr_sat);
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < ppa_pkg::BAR_SIZE; i++) begin
         count = count + 4'(bits[i]);
      end
   end

   assign result.bar_bits    = bits;
   assign result.level       = count;
   assign result.distance_cm = dist_cm;

endmodule

@@ hdl/ppa_tick.sv @@
// ----------------------------------------------------------------------------
// ppa_tick: tick update of beeper, status LED and hold counters
// Next state for one tick at the current proximity level.
// ----------------------------------------------------------------------------
module ppa_tick (
   input  ppa_pkg::state_type  cur,
   input  ppa_pkg::cfg_type    cfg,
   input  logic                mute,
   output ppa_pkg::state_type  nxt
);

   logic allow;
   logic beep_band;

   assign beep_band = (cur.level >= ppa_pkg::LEVEL_BEEP_LOW) &&
                      (cur.level <= ppa_pkg::LEVEL_BEEP_HIGH);

   always_comb begin
      nxt = cur;
      allow = 1'b0;
      nxt.blink_count = cur.blink_count + 16'd1;
      nxt.beep_count  = cur.beep_count + 16'd1;

      if (beep_band) begin
         if (nxt.beep_count >= 16'(ppa_pkg::beep_period(cur.level))) begin
            allow = !mute;
            if (cur.level == ppa_pkg::LEVEL_BEEP_HIGH) begin
               allow = allow && (cur.beep_hold_count < cfg.beep_hold_limit);
               if (allow) begin
                  nxt.beep_hold_count = cur.beep_hold_count + 16'd1;
               end
            end
            nxt.beeper_bit = allow ? !cur.beeper_bit : 1'b0;
            nxt.status_bit = !cur.status_bit;
            nxt.beep_count = '0;
         end
         if (cur.level == ppa_pkg::LEVEL_HOLD_CLR) begin
            nxt.beep_hold_count = '0;
         end
         if (cur.level == ppa_pkg::LEVEL_BEEP_HIGH) begin
            nxt.display_hold_count = '0;
         end
         nxt.blink_count = '0;
      end else if (cur.level >= ppa_pkg::LEVEL_STEADY) begin
         // steady tone while the hold budget lasts
         if (!mute && (cur.beep_hold_count < cfg.beep_hold_limit)) begin
            nxt.beeper_bit      = 1'b1;
            nxt.beep_hold_count = cur.beep_hold_count + 16'd1;
         end else begin
            nxt.beeper_bit = 1'b0;
         end
         nxt.status_bit = 1'b1;
         nxt.beep_count = '0;
         if (cur.display_hold_count < ppa_pkg::DISPLAY_COUNT_CAP) begin
            nxt.display_hold_count = cur.display_hold_count + 16'd1;
         end
         nxt.blink_count = '0;
      end else begin
         nxt.beeper_bit = 1'b0;
         if (nxt.blink_count >= ppa_pkg::SLOW_BLINK) begin
            nxt.status_bit  = !cur.status_bit;
            nxt.blink_count = '0;
         end
      end
   end

endmodule
